[rtl/avd_pkg.sv]
// Shared types, constants and the CRC step for the asset directory validator.
`timescale 1ns / 1ps
package avd_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NAME_BYTES  = 16;
  localparam int NAME_W      = 8 * NAME_BYTES;
  localparam int SPAN_W      = 64;

  localparam logic [15:0] HDR_LEN   = 16'd16;
  localparam logic [15:0] ENT_LEN   = 16'd28;
  localparam logic [4:0]  ENT_LAST  = 5'd27;
  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [31:0] HDR_MAGIC = 32'h31415641;  // bytes 0..3, little-endian

  // table walk counter, one bit wider than a table index
  typedef logic [IDX_W:0] cnt_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_BOUNDS = 3'd2,
    ST_CRC    = 3'd3,
    ST_CAP    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_BYTE,
    S_RD,
    S_CMP
  } seq_state_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       first_byte;
  } avd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  entry_count;
    logic [15:0] header_bytes;
    logic [31:0] total_bytes;
  } avd_out_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [SPAN_W-1:0] span;
  } dir_entry_t;

  // One byte of reflected CRC-32.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[rtl/avd_name_check.sv]
// Entry name rule check: 1 to 15 allowed characters, then zero padding.
`timescale 1ns / 1ps
module avd_name_check (
  input  logic [avd_pkg::NAME_W-1:0] name,
  output logic                       name_ok
);

  logic [avd_pkg::NAME_BYTES-1:0] char_ok;
  logic [avd_pkg::NAME_BYTES-1:0] nz;

  always_comb begin
    for (int n = 0; n < avd_pkg::NAME_BYTES; n++) begin
      logic [7:0] c;
      c = name[8*n +: 8];
      nz[n] = (c != 8'd0);
      char_ok[n] = !nz[n] || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39) ||
                   (c == 8'h5f) || (c == 8'h2d);
    end
  end

  always_comb begin
    name_ok = nz[0] && !nz[avd_pkg::NAME_BYTES-1] && (&char_ok);
    // no nonzero byte after the first zero
    for (int n = 1; n < avd_pkg::NAME_BYTES; n++) begin
      if (nz[n] && !nz[n-1]) begin
        name_ok = 1'b0;
      end
    end
  end

endmodule

[rtl/avd_dir_ram.sv]
// Directory table: name and span of each accepted entry, registered read.
`timescale 1ns / 1ps
module avd_dir_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [avd_pkg::IDX_W-1:0] wr_addr,
  input  avd_pkg::dir_entry_t      wr_data,
  input  logic                     rd_en,
  input  logic [avd_pkg::IDX_W-1:0] rd_addr,
  output avd_pkg::dir_entry_t      rd_data
);

  avd_pkg::dir_entry_t mem [avd_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/asset_directory_validator.sv]
// Top level: byte sequencer, header checks and directory walk.
`timescale 1ns / 1ps
// Usage:
//  The in_ channel carries the image one byte per item; first_byte marks
//  byte 0 of a new image and restarts validation at any point. Bytes
//  without first_byte after a result (or after reset) are taken and dropped.
//  The cfg_ channel writes image_bytes; it is always ready and should only
//  be written between images.
//  One status item comes out on the out_ channel per image: after header
//  byte 15 on a header fault, else with the last directory byte.
//  Throughput: one byte per cycle while no result waits, except at the last
//  byte of directory entry i, which walks the table of earlier entries held
//  in a single-port read RAM: a read state, then a compare state for each
//  earlier entry, stopping early at the first duplicate or overlap.
//  A result is registered and shows in the cycle after its byte or walk end;
//  while it waits for out_ready, in_ready stays low, so a receiver stall
//  holds the input side.
//  Reset clears all control state and image_bytes; the table needs no
//  clearing since entries are read only after being written in the image.
module asset_directory_validator (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  avd_pkg::avd_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output avd_pkg::avd_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_image_bytes
);

  avd_pkg::seq_state_t state_r, state_nxt;
  logic [31:0] image_bytes_r;
  logic [12:0] pos_r, pos_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] size_r, size_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] crc_r, crc_nxt;
  avd_pkg::status_t err_r, err_nxt;
  logic [avd_pkg::NAME_W-1:0] name_r, name_nxt;
  logic [avd_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [avd_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [avd_pkg::IDX_W-1:0] j_r, j_nxt;
  logic        last_r, last_nxt;
  logic        finished_r, finished_nxt;
  logic        out_valid_r, out_valid_nxt;
  avd_pkg::avd_out_t out_r, out_nxt;

  logic                wr_en, rd_en;
  avd_pkg::dir_entry_t wr_data, rd_data;
  logic                name_ok;

  avd_name_check u_name (
    .name    (name_r),
    .name_ok (name_ok)
  );

  avd_dir_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (j_r),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == avd_pkg::S_BYTE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign wr_data   = '{name: name_r, span: span_r};

  always_comb begin
    logic [31:0] off, len, po, pl;
    logic [15:0] expect_size;
    logic [16:0] pos_inc;
    logic        span_bad, last, walk, emit;
    logic [2:0]  emit_st;
    avd_pkg::cnt_t j_inc;

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    total_nxt     = total_r;
    scrc_nxt      = scrc_r;
    crc_nxt       = crc_r;
    err_nxt       = err_r;
    name_nxt      = name_r;
    span_nxt      = span_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    last_nxt      = last_r;
    finished_nxt  = finished_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    emit          = 1'b0;
    emit_st       = avd_pkg::ST_OK;
    walk          = 1'b0;

    off = span_r[31:0];
    len = span_r[63:32];
    po  = rd_data.span[31:0];
    pl  = rd_data.span[63:32];
    span_bad = (off[1:0] != 2'd0) || (len == 32'd0) || (off < {16'd0, size_r}) ||
               (off > total_r) || (len > total_r - off);
    expect_size = avd_pkg::HDR_LEN + 16'(count_r) * avd_pkg::ENT_LEN;
    pos_inc = 17'(pos_r) + 17'd1;
    last = (pos_inc >= {1'b0, size_r});
    j_inc = avd_pkg::cnt_t'(j_r) + avd_pkg::cnt_t'(1);

    case (state_r)
      avd_pkg::S_BYTE: begin
        if (in_valid && in_ready && (in_data.first_byte || !finished_r)) begin
          if (in_data.first_byte) begin
            pos_nxt   = '0;
            count_nxt = '0;
            size_nxt  = '0;
            total_nxt = '0;
            scrc_nxt  = '0;
            crc_nxt   = avd_pkg::CRC_INIT;
            err_nxt   = avd_pkg::ST_OK;
            name_nxt  = '0;
            span_nxt  = '0;
            k_nxt     = '0;
            idx_nxt   = '0;
            finished_nxt = 1'b0;
          end
          pos_nxt = pos_nxt + 13'd1;
          if (!in_data.first_byte && pos_r >= 13'(avd_pkg::HDR_LEN)) begin
            // directory byte
            crc_nxt = avd_pkg::crc_byte(crc_r, in_data.image_byte);
            if (k_r < 5'd16) begin
              name_nxt[8*k_r[3:0] +: 8] = in_data.image_byte;
            end else if (k_r < 5'd24) begin
              span_nxt[8*k_r[2:0] +: 8] = in_data.image_byte;
            end
            if (k_r == avd_pkg::ENT_LAST) begin
              k_nxt   = '0;
              idx_nxt = idx_r + 1'b1;
              if (err_r == avd_pkg::ST_OK) begin
                if (!name_ok) begin
                  err_nxt = avd_pkg::ST_FORMAT;
                end else if (span_bad) begin
                  err_nxt = avd_pkg::ST_BOUNDS;
                end else if (idx_r == '0) begin
                  wr_en = 1'b1;
                end else begin
                  walk = 1'b1;
                end
              end
              if (walk) begin
                idx_nxt   = idx_r;  // kept as write address until the walk ends
                state_nxt = avd_pkg::S_RD;
                j_nxt     = '0;
                last_nxt  = last;
              end else begin
                name_nxt = '0;
                span_nxt = '0;
              end
            end else begin
              k_nxt = k_r + 5'd1;
            end
            if (last && !walk) begin
              emit    = 1'b1;
              emit_st = ((crc_nxt ^ avd_pkg::CRC_INIT) != scrc_r) ? avd_pkg::ST_CRC : err_nxt;
            end
          end else begin
            // header byte; position is 0 on a first byte
            logic [3:0] p;
            p = in_data.first_byte ? 4'd0 : pos_r[3:0];
            if (p < 4'd4) begin
              if (in_data.image_byte != avd_pkg::HDR_MAGIC[8*p[1:0] +: 8]) begin
                err_nxt = avd_pkg::ST_FORMAT;
              end
            end else if (p == 4'd4) begin
              if (in_data.image_byte != 8'd1) err_nxt = avd_pkg::ST_FORMAT;
            end else if (p == 4'd5) begin
              count_nxt = in_data.image_byte;
              if (in_data.image_byte == 8'd0) err_nxt = avd_pkg::ST_FORMAT;
            end else if (p < 4'd8) begin
              size_nxt[8*p[0] +: 8] = in_data.image_byte;
            end else if (p < 4'd12) begin
              total_nxt[8*p[1:0] +: 8] = in_data.image_byte;
            end else begin
              scrc_nxt[8*p[1:0] +: 8] = in_data.image_byte;
            end
            if (p == 4'd15) begin
              if (image_bytes_r < 32'(avd_pkg::HDR_LEN) || err_r != avd_pkg::ST_OK) begin
                emit = 1'b1; emit_st = avd_pkg::ST_FORMAT;
              end else if (size_r != expect_size || total_r < {16'd0, size_r} ||
                           total_r > image_bytes_r) begin
                emit = 1'b1; emit_st = avd_pkg::ST_BOUNDS;
              end else if (count_r > 8'(avd_pkg::MAX_ENTRIES)) begin
                emit = 1'b1; emit_st = avd_pkg::ST_CAP;
              end
            end
          end
        end
      end
      avd_pkg::S_RD: begin
        rd_en     = 1'b1;
        state_nxt = avd_pkg::S_CMP;
      end
      avd_pkg::S_CMP: begin
        logic done;
        done = 1'b1;
        if (rd_data.name == name_r) begin
          err_nxt = avd_pkg::ST_FORMAT;
        end else if ({1'b0, off} < {1'b0, po} + {1'b0, pl} &&
                     {1'b0, po} < {1'b0, off} + {1'b0, len}) begin
          err_nxt = avd_pkg::ST_BOUNDS;
        end else if (j_inc == avd_pkg::cnt_t'(idx_r)) begin
          wr_en = 1'b1;
        end else begin
          done  = 1'b0;
          j_nxt = j_r + 1'b1;
          state_nxt = avd_pkg::S_RD;
        end
        if (done) begin
          state_nxt = avd_pkg::S_BYTE;
          idx_nxt   = idx_r + 1'b1;
          name_nxt  = '0;
          span_nxt  = '0;
          if (last_r) begin
            emit    = 1'b1;
            emit_st = ((crc_r ^ avd_pkg::CRC_INIT) != scrc_r) ? avd_pkg::ST_CRC : err_nxt;
          end
        end
      end
      default: state_nxt = avd_pkg::S_BYTE;
    endcase

    if (emit) begin
      finished_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
      out_nxt = '{status: emit_st, entry_count: count_nxt, header_bytes: size_nxt,
                  total_bytes: total_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= avd_pkg::S_BYTE;
      image_bytes_r <= '0;
      pos_r         <= '0;
      count_r       <= '0;
      size_r        <= '0;
      total_r       <= '0;
      scrc_r        <= '0;
      crc_r         <= avd_pkg::CRC_INIT;
      err_r         <= avd_pkg::ST_OK;
      name_r        <= '0;
      span_r        <= '0;
      k_r           <= '0;
      idx_r         <= '0;
      j_r           <= '0;
      last_r        <= 1'b0;
      finished_r    <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) image_bytes_r <= cfg_image_bytes;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      total_r     <= total_nxt;
      scrc_r      <= scrc_nxt;
      crc_r       <= crc_nxt;
      err_r       <= err_nxt;
      name_r      <= name_nxt;
      span_r      <= span_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      last_r      <= last_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the asset directory validator: queued byte driver, result monitor.
`timescale 1ns / 1ps
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  avd_pkg::avd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  avd_pkg::avd_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_image_bytes = '0;

  always #5 clk = ~clk;

  asset_directory_validator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_image_bytes(cfg_image_bytes)
  );

  // predictor state
  logic [31:0] pr_image_bytes;
  logic [12:0] pr_pos;
  logic [7:0]  pr_count;
  logic [15:0] pr_size;
  logic [31:0] pr_total, pr_stored, pr_crc;
  logic [2:0]  pr_err;
  logic [7:0]  pr_name [16];
  logic [63:0] pr_span;
  logic [7:0]  pr_names [avd_pkg::MAX_ENTRIES][16];
  logic [63:0] pr_spans [avd_pkg::MAX_ENTRIES];
  logic        pr_idle;

  avd_pkg::avd_in_t  byte_q [$];
  avd_pkg::avd_out_t status_q [$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int ITEM_TARGET = 1650;

  // injected image faults
  localparam int F_NONE      = 0;
  localparam int F_MAGIC     = 1;
  localparam int F_VERSION   = 2;
  localparam int F_SIZE      = 3;
  localparam int F_TOTAL     = 4;
  localparam int F_CRC       = 5;
  localparam int F_NAME      = 6;
  localparam int F_ALIGN     = 7;
  localparam int F_DUP       = 8;
  localparam int F_OVERLAP   = 9;
  localparam int F_ZERO_CNT  = 10;
  localparam int F_FLIP      = 11;
  localparam int F_SHORT_LEN = 12;

  function automatic bit name_valid();
    int n;
    logic [7:0] c;
    n = 0;
    while (n < 16 && pr_name[n] != 8'd0) begin
      c = pr_name[n];
      if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_" || c == "-"))
        return 0;
      n++;
    end
    if (n == 0 || n > 15) return 0;
    for (; n < 16; n++) if (pr_name[n] != 8'd0) return 0;
    return 1;
  endfunction

  function automatic logic [2:0] entry_status(int idx);
    logic [31:0] off, len;
    logic [63:0] po, pl;
    bit same;
    off = pr_span[31:0];
    len = pr_span[63:32];
    if (!name_valid()) return avd_pkg::ST_FORMAT;
    if (off[1:0] != 2'd0 || len == 0 || off < {16'd0, pr_size} || off > pr_total ||
        len > pr_total - off) return avd_pkg::ST_BOUNDS;
    for (int j = 0; j < idx && j < avd_pkg::MAX_ENTRIES; j++) begin
      po = {32'd0, pr_spans[j][31:0]};
      pl = {32'd0, pr_spans[j][63:32]};
      same = 1;
      for (int k = 0; k < 16; k++) if (pr_name[k] != pr_names[j][k]) same = 0;
      if (same) return avd_pkg::ST_FORMAT;
      if ({32'd0, off} < po + pl && po < {32'd0, off} + {32'd0, len})
        return avd_pkg::ST_BOUNDS;
    end
    return avd_pkg::ST_OK;
  endfunction

  function automatic void post_status(logic [2:0] st);
    avd_pkg::avd_out_t r;
    r.status = st;
    r.entry_count = pr_count;
    r.header_bytes = pr_size;
    r.total_bytes = pr_total;
    status_q.push_back(r);
    pr_idle = 1;
  endfunction

  function automatic void predict_byte(avd_pkg::avd_in_t it);
    int pos, rel, k, idx;
    logic [7:0] b;
    logic [7:0] magic [4];
    magic = '{8'h41, 8'h56, 8'h41, 8'h31};
    b = it.image_byte;
    if (it.first_byte) begin
      pr_pos = 0; pr_count = 0; pr_size = 0; pr_total = 0; pr_stored = 0;
      pr_crc = 32'hffffffff; pr_err = avd_pkg::ST_OK; pr_span = 0;
      for (int i = 0; i < 16; i++) pr_name[i] = 0;
      pr_idle = 0;
    end else if (pr_idle) return;
    pos = pr_pos;
    pr_pos = pr_pos + 13'd1;
    if (pos < 16) begin
      if (pos < 4) begin
        if (b != magic[pos]) pr_err = avd_pkg::ST_FORMAT;
      end else if (pos == 4) begin
        if (b != 8'd1) pr_err = avd_pkg::ST_FORMAT;
      end else if (pos == 5) begin
        pr_count = b;
        if (b == 0) pr_err = avd_pkg::ST_FORMAT;
      end else if (pos < 8) pr_size[8*(pos-6) +: 8] = b;
      else if (pos < 12) pr_total[8*(pos-8) +: 8] = b;
      else pr_stored[8*(pos-12) +: 8] = b;
      if (pos == 15) begin
        if (pr_image_bytes < 16 || pr_err != avd_pkg::ST_OK) post_status(avd_pkg::ST_FORMAT);
        else if ({16'd0, pr_size} != 32'd16 + 32'd28 * pr_count || pr_total < pr_size ||
                 pr_total > pr_image_bytes) post_status(avd_pkg::ST_BOUNDS);
        else if (pr_count > avd_pkg::MAX_ENTRIES) post_status(avd_pkg::ST_CAP);
      end
      return;
    end
    rel = pos - 16;
    k = rel % 28;
    idx = rel / 28;
    pr_crc = pr_crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) pr_crc = (pr_crc >> 1) ^ (32'hedb88320 & {32{pr_crc[0]}});
    if (k < 16) pr_name[k] = b;
    else if (k < 24) pr_span[8*(k-16) +: 8] = b;
    if (k == 27) begin
      if (pr_err == avd_pkg::ST_OK) begin
        pr_err = entry_status(idx);
        if (pr_err == avd_pkg::ST_OK && idx < avd_pkg::MAX_ENTRIES) begin
          pr_names[idx] = pr_name;
          pr_spans[idx] = pr_span;
        end
      end
      for (int i = 0; i < 16; i++) pr_name[i] = 0;
      pr_span = 0;
    end
    if (pos + 1 >= pr_size) begin
      if (~pr_crc != pr_stored) post_status(avd_pkg::ST_CRC);
      else post_status(pr_err);
    end
  endfunction

  // image builder
  logic [7:0] img [$];

  function automatic logic [31:0] crc_of(int from);
    logic [31:0] c;
    c = 32'hffffffff;
    for (int i = from; i < img.size(); i++) begin
      c = c ^ {24'd0, img[i]};
      for (int j = 0; j < 8; j++) c = (c >> 1) ^ (32'hedb88320 & {32{c[0]}});
    end
    return ~c;
  endfunction

  function automatic void put32(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) img[at+i] = v[8*i +: 8];
  endfunction

  function automatic void build_image(int cnt, int fault);
    string chars;
    int nlen, base, off;
    logic [31:0] total;
    chars = "abcdefghijklmnopqrstuvwxyz0123456789_-";
    img.delete();
    total = 32'd16 + 28 * cnt + 64 * cnt + 64;
    img.push_back(8'h41); img.push_back(8'h56); img.push_back(8'h41); img.push_back(8'h31);
    img.push_back(8'd1); img.push_back(cnt[7:0]);
    img.push_back(8'(16 + 28 * cnt)); img.push_back(8'((16 + 28 * cnt) >> 8));
    for (int i = 0; i < 8; i++) img.push_back(8'd0);
    put32(8, total);
    off = 16 + 28 * cnt;
    for (int e = 0; e < cnt; e++) begin
      base = img.size();
      nlen = $urandom_range(1, 15);
      for (int i = 0; i < 16; i++)
        img.push_back(i == 0 ? 8'(e + 97) : i < nlen ? 8'(chars[$urandom_range(0, 37)]) : 8'd0);
      for (int i = 0; i < 8; i++) img.push_back(8'd0);
      for (int i = 0; i < 4; i++) img.push_back(8'($urandom));
      put32(base + 16, off);
      put32(base + 20, $urandom_range(1, 64));
      off += 64;
    end
    if (cnt > 0) begin
      base = 16 + 28 * $urandom_range(0, cnt - 1);
      case (fault)
        F_NAME: img[base + $urandom_range(0, 15)] = 8'($urandom_range(0, 1) ? 8'h41 : 8'hff);
        F_ALIGN: img[base + 16] = img[base + 16] | 8'd1;
        F_DUP: if (base > 16) for (int i = 0; i < 16; i++) img[base + i] = img[16 + i];
        F_OVERLAP: if (base > 16) put32(base + 16, 16 + 28 * cnt + 8);
        F_SHORT_LEN: put32(base + 20, 0);
        default: ;
      endcase
      if (fault == F_FLIP) img[16 + $urandom_range(0, 28 * cnt - 1)] = 8'($urandom);
    end
    put32(12, crc_of(16));
    case (fault)
      F_MAGIC: img[$urandom_range(0, 3)] = 8'($urandom_range(0, 255) ^ 8'h80);
      F_VERSION: img[4] = 8'($urandom_range(2, 255));
      F_SIZE: img[6] = img[6] ^ 8'd4;
      F_TOTAL: put32(8, $urandom_range(0, 1) ? 32'd10 : 32'hffffffff);
      F_CRC: img[12 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      F_ZERO_CNT: img[5] = 8'd0;
      default: ;
    endcase
  endfunction

  function automatic void queue_image(int chop);
    avd_pkg::avd_in_t it;
    int n;
    n = chop > 0 && chop < img.size() ? chop : img.size();
    for (int i = 0; i < n; i++) begin
      it.image_byte = img[i];
      it.first_byte = (i == 0);
      byte_q.push_back(it);
    end
    sent += n;
  endfunction

  function automatic void queue_noise(int n);
    avd_pkg::avd_in_t it;
    for (int i = 0; i < n; i++) begin
      it.image_byte = 8'($urandom);
      it.first_byte = ($urandom_range(0, 7) == 0);
      byte_q.push_back(it);
    end
    sent += n;
  endfunction

  task automatic wait_drain();
    while (byte_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_image_bytes <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pr_image_bytes = v;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_byte(in_data);
        in_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
      end
      if ((in_valid && !in_ready)) ;
      else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (byte_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= byte_q.pop_front();
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int out_gap = 0;
  avd_pkg::avd_out_t want;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected status item %p", out_data);
        end else begin
          want = status_q.pop_front();
          if (out_data.status != want.status || out_data.entry_count != want.entry_count ||
              out_data.header_bytes != want.header_bytes ||
              out_data.total_bytes != want.total_bytes) begin
            errors++;
            if (errors <= 10) $display("status mismatch: exp %p got %p", want, out_data);
          end
        end
        out_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
      end
      if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    int cnt, fault;
    pr_image_bytes = 0;
    pr_idle = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // image size below the header length
    queue_noise(3);
    build_image(1, F_NONE); queue_image(0);
    wait_drain();
    write_cfg(32'hffffffff);
    for (int f = F_NONE; f <= F_SHORT_LEN; f++) begin
      build_image((f == F_DUP || f == F_OVERLAP) ? 3 : 2, f); queue_image(0);
    end
    build_image(1, F_NONE); queue_image(0);
    // over capacity and a restart mid-image
    build_image(avd_pkg::MAX_ENTRIES + 1, F_NONE); queue_image(16);
    build_image(2, F_NONE); queue_image(30);
    build_image(2, F_NONE); queue_image(0);
    wait_drain();
    write_cfg(32'd0);
    build_image(2, F_NONE); queue_image(0);
    wait_drain();
    write_cfg(32'd500);
    build_image(4, F_NONE); queue_image(0);
    wait_drain();
    write_cfg(32'hffffffff);
    while (sent < ITEM_TARGET) begin
      cnt = $urandom_range(0, 15) == 0 ? $urandom_range(5, 8) : $urandom_range(1, 3);
      fault = $urandom_range(0, 2) == 0 ? $urandom_range(F_MAGIC, F_SHORT_LEN) : F_NONE;
      build_image(cnt, fault);
      queue_image($urandom_range(0, 11) == 0 ? $urandom_range(1, img.size()) : 0);
      if ($urandom_range(0, 9) == 0) queue_noise($urandom_range(1, 10));
    end
    wait_drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
